// File: rtl/iphp_pkg.sv
// Shared types and constants for the IPv4 header parser.
// Holds the packet record passed from front to back, the result layout and codes.
// No dependencies.
package iphp_pkg;

    localparam int LENGTH_WIDTH     = 16;
    localparam int MIN_HEADER_BYTES = 20;
    localparam int MAX_HEADER_BYTES = 60;
    localparam int QUEUE_DEPTH      = 2;
    localparam int OUT_PAD_BITS     = 6;

    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [15:0] CSUM_GOOD  = 16'hFFFF;
    localparam logic [3:0]  IP_VERSION = 4'd4;

    localparam logic [7:0] OPT_END = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;

    localparam logic [0:0] REG_CHECKSUM_ENABLE = 1'b0;
    localparam logic [0:0] REG_OPTIONS_ENABLE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_VERSION = 3'd2,
        ST_FORMAT  = 3'd3,
        ST_MORE    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_TYPE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_STOP = 4'b1000
    } phase_t;

    typedef struct packed {
        logic checksum_enable;
        logic options_enable;
    } iphp_cfg_t;

    // Everything the back end needs about one finished packet.
    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [7:0]  service_type;
        logic [15:0] datagram_length;
        logic [15:0] identification;
        logic [15:0] fragment_word;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] byte_count;
        logic [15:0] checksum_sum;
        logic        option_error;
        logic        option_open;
    } iphp_rec_t;

    // Listed high field first so that status lands in the lowest bits.
    typedef struct packed {
        logic [15:0] payload_length;
        logic        checksum_ok;
        logic [31:0] destination_address;
        logic [31:0] source_address;
        logic [7:0]  protocol_number;
        logic [7:0]  time_to_live;
        logic [15:0] fragment_word;
        logic [15:0] identification;
        logic [15:0] datagram_length;
        logic [7:0]  service_type;
        logic [5:0]  header_length;
        status_t     status;
    } iphp_res_t;

endpackage

// File: rtl/ipv4_header_parser_unit.sv
// IPv4 header parser top level: byte stream in, one result record per packet out.
// Throughput: one byte per cycle; each record is registered in the record queue and
// then in the output register. The front end stalls only when the record queue is full;
// the output register lets a waiting record sit while new bytes keep flowing.
// Reset (aresetn, synchronous, active low) clears packet state, queue and
// output valid, and sets both enables to 1. Depends on iphp_pkg and submodules.
module ipv4_header_parser_unit #(
    parameter int QUEUE_DEPTH = iphp_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Config write port: index 0 checksum_enable, index 1 options_enable
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_addr,
    input  logic [0:0]   cfg_wdata,
    // Byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last_byte
    // Result records out
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [8:3] header_length, [16:9] service_type, [32:17] datagram length,
    // [48:33] identification, [64:49] flags and fragment word, [72:65] time_to_live,
    // [80:73] protocol_number, [112:81] source_address,
    // [144:113] destination_address, [145] checksum_ok, [161:146] payload_length,
    // [167:162] zero
    output logic [167:0] m_tdata
);
    import iphp_pkg::*;

    iphp_cfg_t cfg_reg;
    iphp_rec_t front_rec, queue_rec;
    iphp_res_t result;
    logic      rec_push, rec_full, rec_valid, rec_pop;

    // Config registers; the user must write them only while idle, which the block does not enforce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.checksum_enable <= 1'b1;
            cfg_reg.options_enable  <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CHECKSUM_ENABLE: cfg_reg.checksum_enable <= cfg_wdata[0];
                REG_OPTIONS_ENABLE:  cfg_reg.options_enable  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Capture header, sum and walk options; push a record on the last beat.
    iphp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .rec_full (rec_full),
        .rec_push (rec_push),
        .rec_data (front_rec)
    );

    // Decouple front and back so either side can stall alone.
    iphp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (front_rec),
        .full      (rec_full),
        .pop       (rec_pop),
        .valid     (rec_valid),
        .pop_data  (queue_rec)
    );

    // Grade the record and hold the result beat until taken.
    iphp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rec_valid (rec_valid),
        .rec_data  (queue_rec),
        .rec_pop   (rec_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {{OUT_PAD_BITS{1'b0}}, result};

endmodule

// File: rtl/iphp_front.sv
// Front end of the IPv4 header parser: takes packet bytes, captures the fixed
// header, runs the checksum sum and the option walk, and emits one record per packet.
// Depends on iphp_pkg.
module iphp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                rec_full,
    output logic                rec_push,
    output iphp_pkg::iphp_rec_t rec_data
);
    import iphp_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] acc_reg, acc_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic        err_reg, err_next;
    logic [7:0]  hdr_reg [MIN_HEADER_BYTES];
    logic [7:0]  hdr_view [MIN_HEADER_BYTES];

    logic        accept;
    logic        in_header;
    logic [3:0]  ihl_cur;
    logic [15:0] hl_cur;
    logic [15:0] addend;
    logic [16:0] sum_wide;
    logic [7:0]  left_dec;

    assign in_ready = !rec_full;
    assign accept   = in_valid && in_ready;
    assign rec_push = accept && in_last;
    assign in_header = pos_reg < 16'(MIN_HEADER_BYTES);

    // Current header bytes with this beat merged in.
    always_comb begin
        for (int i = 0; i < MIN_HEADER_BYTES; i++) begin
            hdr_view[i] = (in_header && pos_reg[4:0] == 5'(i)) ? in_byte : hdr_reg[i];
        end
    end

    assign ihl_cur = hdr_view[0][3:0];
    assign hl_cur  = {10'd0, ihl_cur, 2'b00};

    // Ones'-complement sum with end-around carry.
    assign addend   = pos_reg[0] ? {8'd0, in_byte} : {in_byte, 8'd0};
    assign sum_wide = {1'b0, acc_reg} + {1'b0, addend};
    always_comb begin
        acc_next = acc_reg;
        if (pos_reg < hl_cur) begin
            acc_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
        end
    end

    assign left_dec = left_reg - 8'd1;

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        if (!in_header) begin
            unique case (phase_reg)
                PH_TYPE: begin
                    if (pos_reg >= hl_cur || in_byte == OPT_END) begin
                        phase_next = PH_STOP;
                    end else if (in_byte != OPT_NOP) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (in_byte < 8'd2) begin
                        err_next   = 1'b1;
                        phase_next = PH_STOP;
                    end else begin
                        left_next  = in_byte - 8'd2;
                        phase_next = (in_byte == 8'd2) ? PH_TYPE : PH_DATA;
                    end
                end
                PH_DATA: begin
                    left_next = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_STOP: ;
                default: ;
            endcase
        end
    end

    assign pos_next = (pos_reg == COUNT_MAX) ? pos_reg : pos_reg + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            acc_reg   <= '0;
            phase_reg <= PH_TYPE;
            left_reg  <= '0;
            err_reg   <= 1'b0;
        end else if (accept) begin
            if (in_last) begin
                pos_reg   <= '0;
                acc_reg   <= '0;
                phase_reg <= PH_TYPE;
                left_reg  <= '0;
                err_reg   <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                acc_reg   <= acc_next;
                phase_reg <= phase_next;
                left_reg  <= left_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_header) begin
            hdr_reg[pos_reg[4:0]] <= in_byte;
        end
    end

    always_comb begin
        rec_data.version             = hdr_view[0][7:4];
        rec_data.ihl                 = ihl_cur;
        rec_data.service_type        = hdr_view[1];
        rec_data.datagram_length     = {hdr_view[2], hdr_view[3]};
        rec_data.identification      = {hdr_view[4], hdr_view[5]};
        rec_data.fragment_word       = {hdr_view[6], hdr_view[7]};
        rec_data.time_to_live        = hdr_view[8];
        rec_data.protocol_number     = hdr_view[9];
        rec_data.source_address      = {hdr_view[12], hdr_view[13], hdr_view[14], hdr_view[15]};
        rec_data.destination_address = {hdr_view[16], hdr_view[17], hdr_view[18], hdr_view[19]};
        rec_data.byte_count          = pos_next;
        rec_data.checksum_sum        = acc_next;
        rec_data.option_error        = err_next;
        rec_data.option_open         = (phase_next == PH_LEN) || (phase_next == PH_DATA);
    end

endmodule

// File: rtl/iphp_queue.sv
// Short record queue between the parser front and back ends.
// Depends on iphp_pkg for the record type.
module iphp_queue #(
    parameter int DEPTH = iphp_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  iphp_pkg::iphp_rec_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output iphp_pkg::iphp_rec_t pop_data
);
    import iphp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iphp_rec_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign valid    = count_reg != '0;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/iphp_back.sv
// Back end of the IPv4 header parser: grades one packet record and holds the
// result in an output register. Depends on iphp_pkg.
module iphp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  iphp_pkg::iphp_cfg_t cfg,
    input  logic                rec_valid,
    input  iphp_pkg::iphp_rec_t rec_data,
    output logic                rec_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output iphp_pkg::iphp_res_t out_data
);
    import iphp_pkg::*;

    logic        valid_reg;
    iphp_res_t   res_reg, res_next;
    status_t     status;
    logic [15:0] hl16, pay, avail;
    logic        opts_on;

    assign hl16    = {10'd0, rec_data.ihl, 2'b00};
    assign opts_on = cfg.options_enable && hl16 > 16'(MIN_HEADER_BYTES);
    assign pay     = rec_data.datagram_length - hl16;
    assign avail   = rec_data.byte_count - hl16;

    always_comb begin
        priority if (rec_data.byte_count < 16'(MIN_HEADER_BYTES)) begin
            status = ST_SHORT;
        end else if (rec_data.version != IP_VERSION) begin
            status = ST_VERSION;
        end else if (hl16 < 16'(MIN_HEADER_BYTES) || hl16 > 16'(MAX_HEADER_BYTES)) begin
            status = ST_FORMAT;
        end else if (rec_data.byte_count < hl16) begin
            status = ST_SHORT;
        end else if (opts_on && rec_data.option_error) begin
            status = ST_FORMAT;
        end else if (opts_on && rec_data.option_open) begin
            status = ST_MORE;
        end else if (rec_data.datagram_length < hl16) begin
            status = ST_FORMAT;
        end else begin
            status = ST_OK;
        end
    end

    // Zero every field but the status of an error record.
    always_comb begin
        res_next        = '0;
        res_next.status = status;
        if (status == ST_OK) begin
            res_next.header_length       = hl16[5:0];
            res_next.service_type        = rec_data.service_type;
            res_next.datagram_length     = rec_data.datagram_length;
            res_next.identification      = rec_data.identification;
            res_next.fragment_word       = rec_data.fragment_word;
            res_next.time_to_live        = rec_data.time_to_live;
            res_next.protocol_number     = rec_data.protocol_number;
            res_next.source_address      = rec_data.source_address;
            res_next.destination_address = rec_data.destination_address;
            res_next.checksum_ok         = !cfg.checksum_enable ||
                                           rec_data.checksum_sum == CSUM_GOOD;
            res_next.payload_length      = (pay > avail) ? avail : pay;
        end
    end

    assign rec_pop   = rec_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rec_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            res_reg <= res_next;
        end
    end

endmodule

// File: tb/tb.sv
// Self-checking bench for ipv4_header_parser_unit: byte stream in, one header record per packet.
// Builds IPv4 packets on the fly, predicts each record and compares it field by field.
// Depends on iphp_pkg and the parser RTL.
module tb;
    import iphp_pkg::*;

    // Shapes of the option area a generated packet can carry.
    typedef enum int {FILL_LIST, FILL_OVERRUN, FILL_BADLEN, FILL_RANDOM} fill_t;
    // Receiver pacing patterns.
    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_TRICKLE} rx_pace_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [0:0]   cfg_addr  = '0;
    logic [0:0]   cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;   // [7:0] data_byte
    logic         s_tlast   = 1'b0; // last_byte
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [167:0] m_tdata;          // packed iphp_res_t in [161:0], zero above

    ipv4_header_parser_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Shadow of the parser's packet state and its two enables.
    logic [15:0] rx_count;
    logic [7:0]  rx_hdr [0:19];
    logic [15:0] rx_sum;
    phase_t      rx_phase;
    logic [7:0]  rx_opt_left;
    logic        rx_opt_bad;
    logic        want_csum;
    logic        want_opts;

    iphp_res_t   records_due[$];   // predicted records, oldest first
    logic [7:0]  frame_bytes[$];   // packet being built for sending
    int          err_count    = 0;
    int          records_seen = 0;
    int          burst_left   = 0;
    int          rdy_tick     = 0;
    rx_pace_t    rdy_mode     = RX_OPEN;

    task automatic clear_tracker();
        rx_count = '0;
        foreach (rx_hdr[i]) rx_hdr[i] = '0;
        rx_sum      = '0;
        rx_phase    = PH_TYPE;
        rx_opt_left = '0;
        rx_opt_bad  = 1'b0;
    endtask

    // Advance the shadow state by one accepted beat; on the last beat queue the record.
    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [15:0] pos, hl, n, tl, pay, avail;
        logic [16:0] acc;
        status_t     st;
        iphp_res_t   rec;
        pos = rx_count;
        if (pos < MIN_HEADER_BYTES) rx_hdr[pos] = b;
        hl = {10'd0, rx_hdr[0][3:0], 2'b00};
        // Ones'-complement sum of big-endian words, end-around carry each step.
        if (pos < hl) begin
            acc    = {1'b0, rx_sum} + (pos[0] ? {9'd0, b} : {1'b0, b, 8'd0});
            rx_sum = acc[15:0] + {15'd0, acc[16]};
        end
        if (pos >= MIN_HEADER_BYTES) begin
            case (rx_phase)
                PH_TYPE: begin
                    if (pos >= hl || b == OPT_END) rx_phase = PH_STOP;
                    else if (b != OPT_NOP) rx_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (b < 8'd2) begin
                        rx_opt_bad = 1'b1;
                        rx_phase   = PH_STOP;
                    end else begin
                        rx_opt_left = b - 8'd2;
                        rx_phase    = (rx_opt_left != 0) ? PH_DATA : PH_TYPE;
                    end
                end
                PH_DATA: begin
                    rx_opt_left = rx_opt_left - 8'd1;
                    if (rx_opt_left == 0) rx_phase = PH_TYPE;
                end
                default: ;
            endcase
        end
        if (rx_count != COUNT_MAX) rx_count = rx_count + 16'd1;
        if (last) begin
            n  = rx_count;
            tl = {rx_hdr[2], rx_hdr[3]};
            if (n < MIN_HEADER_BYTES) st = ST_SHORT;
            else if (rx_hdr[0][7:4] != IP_VERSION) st = ST_VERSION;
            else if (hl < MIN_HEADER_BYTES || hl > MAX_HEADER_BYTES) st = ST_FORMAT;
            else if (n < hl) st = ST_SHORT;
            else if (want_opts && hl > MIN_HEADER_BYTES && rx_opt_bad) st = ST_FORMAT;
            else if (want_opts && hl > MIN_HEADER_BYTES &&
                     (rx_phase == PH_LEN || rx_phase == PH_DATA)) st = ST_MORE;
            else if (tl < hl) st = ST_FORMAT;
            else st = ST_OK;
            // Error records carry nothing but the status.
            rec = '0;
            rec.status = st;
            if (st == ST_OK) begin
                pay   = tl - hl;
                avail = n - hl;
                if (pay > avail) pay = avail;
                rec.header_length       = hl[5:0];
                rec.service_type        = rx_hdr[1];
                rec.datagram_length     = tl;
                rec.identification      = {rx_hdr[4], rx_hdr[5]};
                rec.fragment_word       = {rx_hdr[6], rx_hdr[7]};
                rec.time_to_live        = rx_hdr[8];
                rec.protocol_number     = rx_hdr[9];
                rec.source_address      = {rx_hdr[12], rx_hdr[13], rx_hdr[14], rx_hdr[15]};
                rec.destination_address = {rx_hdr[16], rx_hdr[17], rx_hdr[18], rx_hdr[19]};
                rec.checksum_ok         = !want_csum || rx_sum == CSUM_GOOD;
                rec.payload_length      = pay;
            end
            records_due.insert(records_due.size(), rec);
            clear_tracker();
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        err_count++;
        $display("tb: record %0d %s: want 0x%0h, got 0x%0h",
                 records_seen, field, want, got);
    endtask

    task automatic check_record(input logic [167:0] data);
        iphp_res_t got, want;
        got = data[161:0];
        if (records_due.size() == 0) begin
            flag_mismatch("unexpected record", 64'd0, data[63:0]);
        end else begin
            want = records_due.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", want.status, got.status);
            if (got.header_length !== want.header_length)
                flag_mismatch("header_length", want.header_length, got.header_length);
            if (got.service_type !== want.service_type)
                flag_mismatch("service_type", want.service_type, got.service_type);
            if (got.datagram_length !== want.datagram_length)
                flag_mismatch("datagram_length", want.datagram_length, got.datagram_length);
            if (got.identification !== want.identification)
                flag_mismatch("identification", want.identification, got.identification);
            if (got.fragment_word !== want.fragment_word)
                flag_mismatch("fragment_word", want.fragment_word, got.fragment_word);
            if (got.time_to_live !== want.time_to_live)
                flag_mismatch("time_to_live", want.time_to_live, got.time_to_live);
            if (got.protocol_number !== want.protocol_number)
                flag_mismatch("protocol_number", want.protocol_number, got.protocol_number);
            if (got.source_address !== want.source_address)
                flag_mismatch("source_address", want.source_address, got.source_address);
            if (got.destination_address !== want.destination_address)
                flag_mismatch("destination_address", want.destination_address,
                              got.destination_address);
            if (got.checksum_ok !== want.checksum_ok)
                flag_mismatch("checksum_ok", want.checksum_ok, got.checksum_ok);
            if (got.payload_length !== want.payload_length)
                flag_mismatch("payload_length", want.payload_length, got.payload_length);
            if (data[167:162] !== 6'd0)
                flag_mismatch("pad bits", 64'd0, data[167:162]);
        end
        records_seen++;
    endtask

    // Inputs change only at rising edges and outputs settle before the falling
    // edge, so the falling edge sees exactly what the next rising edge takes.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) track_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) check_record(m_tdata);
        end
    end

    // Receiver pacing: switch at random among the four patterns.
    always @(posedge aclk) begin
        rdy_tick = rdy_tick + 1;
        if (rdy_tick % 300 == 0) rdy_mode = rx_pace_t'($urandom_range(0, 3));
        case (rdy_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RX_COMB:    m_tready <= (rdy_tick % 8) >= 5;
            RX_TRICKLE: m_tready <= ($urandom_range(0, 9) == 0);
            default:    m_tready <= 1'b1;
        endcase
    end

    // Send one beat; bursts of random length are split by random gaps.
    task automatic send_beat(input logic [7:0] b, input logic last);
        logic ready_seen;
        int   gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(4, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Hold the input idle until every record is back, then let the pipe empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (records_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Write both enables one after the other; only called while idle.
    task automatic apply_config(input logic csum_on, input logic opts_on);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_CHECKSUM_ENABLE;
        cfg_wdata <= csum_on;
        @(posedge aclk);
        cfg_addr  <= REG_OPTIONS_ENABLE;
        cfg_wdata <= opts_on;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        want_csum = csum_on;
        want_opts = opts_on;
    endtask

    // Append one byte to the packet under construction.
    task automatic add_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endtask

    // Zero the checksum word, then store the complement of the header sum there.
    task automatic fill_checksum(input int hl);
        logic [16:0] acc;
        logic [15:0] sum;
        int          i;
        sum = '0;
        frame_bytes[10] = 8'h00;
        frame_bytes[11] = 8'h00;
        for (i = 0; i < hl; i += 2) begin
            acc = {1'b0, sum} + {1'b0, frame_bytes[i], frame_bytes[i + 1]};
            sum = acc[15:0] + {15'd0, acc[16]};
        end
        sum = ~sum;
        frame_bytes[10] = sum[15:8];
        frame_bytes[11] = sum[7:0];
    endtask

    // Build a version-4 packet with the given IHL, payload size and total length.
    task automatic build_packet(input int ihl, input int payload, input int tl,
                                input fill_t style);
        int   hl, lim, room, len, k, i;
        logic stopped;
        frame_bytes.delete();
        hl = ihl * 4;
        add_byte({IP_VERSION, ihl[3:0]});
        repeat (19) add_byte(8'($urandom_range(0, 255)));
        frame_bytes[2] = tl[15:8];
        frame_bytes[3] = tl[7:0];
        // Overrun leaves the last header byte for an option that spills into the payload.
        lim = (style == FILL_OVERRUN && hl > MIN_HEADER_BYTES) ? hl - 1 : hl;
        stopped = 1'b0;
        while (frame_bytes.size() < lim) begin
            k    = $urandom_range(0, 9);
            room = lim - frame_bytes.size();
            if (stopped || style == FILL_RANDOM) begin
                add_byte(8'($urandom_range(0, 255)));
            end else if (k < 3 || room < 2) begin
                add_byte(OPT_NOP);
            end else if (k == 3) begin
                // Past the end-of-list marker anything goes.
                add_byte(OPT_END);
                stopped = 1'b1;
            end else begin
                len = $urandom_range(2, room);
                add_byte(8'($urandom_range(2, 255)));
                add_byte(8'(len));
                repeat (len - 2) add_byte(8'($urandom_range(0, 255)));
            end
        end
        if (lim < hl) add_byte(8'($urandom_range(2, 255)));
        if (style == FILL_BADLEN && hl >= 24) begin
            k = $urandom_range(0, hl - 22);
            for (i = 0; i < k; i++) frame_bytes[20 + i] = OPT_NOP;
            frame_bytes[20 + k] = 8'($urandom_range(2, 255));
            frame_bytes[21 + k] = 8'($urandom_range(0, 1));
        end
        fill_checksum(hl);
        if (lim < hl && payload > 0) add_byte(8'($urandom_range(2, 12)));
        while (frame_bytes.size() < hl + payload) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_status_codes();
        // Lone byte, then one byte short of a header.
        frame_bytes.delete();
        add_byte({IP_VERSION, 4'd5});
        send_packet();
        build_packet(5, 0, 20, FILL_LIST);
        void'(frame_bytes.pop_back());
        send_packet();
        // Wrong version.
        build_packet(5, 4, 24, FILL_LIST);
        frame_bytes[0] = {4'd6, 4'd5};
        send_packet();
        // IHL below five, including zero.
        build_packet(4, 8, 24, FILL_LIST);
        send_packet();
        build_packet(0, 4, 0, FILL_LIST);
        send_packet();
        // Full-size header cut off before its end.
        build_packet(15, 0, 60, FILL_LIST);
        while (frame_bytes.size() > 30) void'(frame_bytes.pop_back());
        send_packet();
        // Total length below header length.
        build_packet(5, 4, 12, FILL_LIST);
        send_packet();
        // Corrupted header: status stays ok, checksum flag drops.
        build_packet(5, 6, 26, FILL_LIST);
        frame_bytes[13] = frame_bytes[13] ^ 8'h10;
        send_packet();
        // Total length beyond the bytes present: payload clipped.
        build_packet(5, 3, 200, FILL_LIST);
        send_packet();
        drain();
    endtask

    task automatic test_field_extremes();
        int i;
        // Every field at its top, IHL 15 padded with NOPs, payload clipped.
        build_packet(15, 10, 65535, FILL_LIST);
        for (i = 1; i < 20; i++)
            if (i != 2 && i != 3) frame_bytes[i] = 8'hFF;
        for (i = 20; i < 60; i++) frame_bytes[i] = OPT_NOP;
        fill_checksum(60);
        send_packet();
        // Everything zero but version, IHL, length and checksum.
        build_packet(5, 0, 20, FILL_LIST);
        for (i = 1; i < 20; i++) frame_bytes[i] = 8'h00;
        frame_bytes[3] = 8'd20;
        fill_checksum(20);
        send_packet();
        drain();
    endtask

    task automatic test_option_walk();
        int i;
        build_packet(8, 4, 36, FILL_BADLEN);
        send_packet();
        // End marker first; the rest would be malformed if walked.
        build_packet(8, 0, 32, FILL_LIST);
        frame_bytes[20] = OPT_END;
        for (i = 21; i < 32; i++) frame_bytes[i] = 8'h07;
        fill_checksum(32);
        send_packet();
        // Last option spills into the payload and completes there.
        build_packet(6, 12, 36, FILL_OVERRUN);
        send_packet();
        // Last option spills and the packet ends inside it.
        build_packet(6, 3, 27, FILL_OVERRUN);
        frame_bytes[24] = 8'd40;
        send_packet();
        drain();
        // With the walk off the same faults pass.
        apply_config(1'b1, 1'b0);
        build_packet(8, 4, 36, FILL_BADLEN);
        send_packet();
        build_packet(6, 3, 27, FILL_OVERRUN);
        frame_bytes[24] = 8'd40;
        send_packet();
        drain();
    endtask

    task automatic test_checksum_disable();
        apply_config(1'b0, 1'b1);
        build_packet(5, 2, 22, FILL_LIST);
        frame_bytes[15] = frame_bytes[15] ^ 8'h01;
        send_packet();
        build_packet(7, 5, 33, FILL_LIST);
        send_packet();
        drain();
    endtask

    task automatic run_random_phase(input logic csum_on, input logic opts_on, input int budget);
        int       sent, kind, ihl, hl, payload, tl, pick, k;
        fill_t    style;
        logic [3:0] ver;
        apply_config(csum_on, opts_on);
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                // Raw noise, any length up to a bit past a header.
                frame_bytes.delete();
                repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(0, 255)));
            end else begin
                if (kind < 25) ihl = $urandom_range(0, 4);
                else ihl = ($urandom_range(0, 2) == 0) ? 5 : $urandom_range(6, 15);
                hl = ihl * 4;
                payload = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                                      : $urandom_range(0, 16);
                pick = $urandom_range(0, 9);
                if (pick < 7) tl = hl + payload;
                else if (pick == 7) tl = hl + payload + $urandom_range(1, 40);
                else if (pick == 8) tl = $urandom_range(0, 65535);
                else tl = (hl == 0) ? 0 : $urandom_range(0, hl - 1);
                pick = $urandom_range(0, 19);
                style = (pick < 11) ? FILL_LIST : (pick < 15) ? FILL_OVERRUN :
                        (pick < 17) ? FILL_BADLEN : FILL_RANDOM;
                build_packet(ihl, payload, tl, style);
                // Break a fraction of the well-formed packets.
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    ver = 4'($urandom_range(0, 14));
                    if (ver >= IP_VERSION) ver = ver + 4'd1;
                    frame_bytes[0] = {ver, frame_bytes[0][3:0]};
                end else if ((pick == 1 || pick == 2) && hl > 4) begin
                    k = $urandom_range(4, hl - 1);
                    frame_bytes[k] = frame_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
                end else if (pick == 3 && frame_bytes.size() > 1) begin
                    k = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > k) void'(frame_bytes.pop_back());
                end
            end
            send_packet();
            sent += frame_bytes.size();
        end
        drain();
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b0, 1'b0, 320);
        run_random_phase(1'b1, 1'b0, 320);
        run_random_phase(1'b0, 1'b1, 320);
        run_random_phase(1'b1, 1'b1, 320);
    endtask

    initial begin
        clear_tracker();
        want_csum = 1'b1;
        want_opts = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed tests start on the reset values of both enables.
        test_status_codes();
        test_field_extremes();
        test_option_walk();
        test_checksum_disable();
        test_random_traffic();
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Hard stop: several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
